// ===== design/ffa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and codes of the first-fit block allocator
// Holds the table entry layout, the request kinds, the status codes and the
// compare modes used by the sequencer, the block table and the compare unit.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned TOP_W   = 17;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;

  // Reset value of the heap limit register.
  localparam logic [TOP_W-1:0] HEAP_LIMIT_RST = 17'h10000;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REALLOC = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO    = 2'd3;

  // One entry of the block table.
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] start;
  } entry_t;

  // What the shared compare unit tests an entry for.
  typedef enum logic {
    CMP_FIND = 1'b0,  // payload address equals the key address
    CMP_FIT  = 1'b1   // entry is free and large enough for the request
  } cmp_mode_t;

endpackage : ffa_pkg
`default_nettype wire

// ===== design/ffa_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_table: block table memory
// One write port and one read port with registered read data. Entries hold
// the payload address, payload size and free mark of each heap block.
// ----------------------------------------------------------------------------
module ffa_table
  import ffa_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule : ffa_table
`default_nettype wire

// ===== design/ffa_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_cmp: shared entry compare unit
// Tests one table entry either for an address match or for a first-fit
// candidate, depending on the mode chosen by the sequencer.
// ----------------------------------------------------------------------------
module ffa_cmp
  import ffa_pkg::*;
(
  input  wire cmp_mode_t           mode,
  input  wire entry_t              entry,
  input  wire logic [ADDR_W-1:0]   key_addr,
  input  wire logic [SIZE_W-1:0]   key_size,
  output logic                     hit
);

  // Equality for address lookup, magnitude compare for the fit search.
  always_comb begin
    unique case (mode)
      CMP_FIND: hit = (entry.start == key_addr);
      CMP_FIT:  hit = entry.free && (entry.size >= key_size);
      default:  hit = 1'b0;
    endcase
  end

endmodule : ffa_cmp
`default_nettype wire

// ===== design/ffa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Walks the block table one entry per cycle through the shared compare
// unit, appends new blocks at the heap top, and holds the result register.
// ----------------------------------------------------------------------------
module ffa_ctrl
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned IDX_W        = 6,
  parameter int unsigned CNT_W        = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Request side
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic [KIND_W-1:0] req_kind,
  input  wire logic [SIZE_W-1:0] req_size,
  input  wire logic [ADDR_W-1:0] req_addr,
  // Result side
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output logic [ADDR_W-1:0]      rsp_addr,
  output logic [SIZE_W-1:0]      rsp_copy,
  output logic [STAT_W-1:0]      rsp_status,
  // Configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [TOP_W-1:0]  cfg_wr_data,
  // Block table
  output logic                   tbl_wr_en,
  output logic [IDX_W-1:0]       tbl_wr_addr,
  output entry_t                 tbl_wr_data,
  output logic                   tbl_rd_en,
  output logic [IDX_W-1:0]       tbl_rd_addr,
  input  wire entry_t            tbl_rd_data
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FIND    = 6'b000010,
    S_FIT     = 6'b000100,
    S_APPEND  = 6'b001000,
    S_RELEASE = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic                move_r, move_nxt;
  logic [IDX_W-1:0]    old_idx_r, old_idx_nxt;
  logic [SIZE_W-1:0]   old_size_r, old_size_nxt;
  logic [ADDR_W-1:0]   res_r, res_nxt;
  logic [SIZE_W-1:0]   copy_r, copy_nxt;
  logic [STAT_W-1:0]   st_r, st_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TOP_W-1:0]    top_r, top_nxt;
  logic [TOP_W-1:0]    limit_r;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [SIZE_W-1:0]   out_copy_r;
  logic [STAT_W-1:0]   out_st_r;

  cmp_mode_t           cmp_mode;
  logic                cmp_hit;
  logic                scan_on;
  logic                issue;
  logic                hit;
  logic                miss;
  logic                out_load;
  logic [TOP_W-1:0]    eff_limit;
  logic [TOP_W:0]      need;
  logic [ADDR_W-1:0]   new_start;
  logic                no_room;

  // Shared compare unit, fed by the registered table read.
  assign cmp_mode = (state_r == S_FIT) ? CMP_FIT : CMP_FIND;

  ffa_cmp u_cmp (
    .mode     (cmp_mode),
    .entry    (tbl_rd_data),
    .key_addr (addr_r),
    .key_size (size_r),
    .hit      (cmp_hit)
  );

  // Scan pipeline: one read issued per cycle, each judged in the cycle after its issue.
  assign scan_on = (state_r == S_FIND) || (state_r == S_FIT);
  assign issue   = scan_on && (rd_idx_r < count_r);
  assign hit     = scan_on && pend_r && cmp_hit;
  assign miss    = scan_on && !pend_r && !issue;

  assign tbl_rd_en   = issue;
  assign tbl_rd_addr = rd_idx_r[IDX_W-1:0];

  // Append arithmetic against the effective heap limit.
  assign eff_limit = (limit_r > TOP_W'(HEAP_BYTES)) ? TOP_W'(HEAP_BYTES) : limit_r;
  assign need      = {1'b0, top_r} + (TOP_W+1)'(HEADER_BYTES)
                     + {{(TOP_W+1-SIZE_W){1'b0}}, size_r};
  assign new_start = top_r[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
  assign no_room   = (count_r == CNT_W'(MAX_BLOCKS)) || (need > {1'b0, eff_limit});

  assign req_ready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || rsp_ready);

  // Sequencer next state.
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    size_nxt     = size_r;
    addr_nxt     = addr_r;
    move_nxt     = move_r;
    old_idx_nxt  = old_idx_r;
    old_size_nxt = old_size_r;
    res_nxt      = res_r;
    copy_nxt     = copy_r;
    st_nxt       = st_r;
    rd_idx_nxt   = '0;
    pend_nxt     = 1'b0;
    pend_idx_nxt = rd_idx_r[IDX_W-1:0];
    count_nxt    = count_r;
    top_nxt      = top_r;
    tbl_wr_en    = 1'b0;
    tbl_wr_addr  = pend_idx_r;
    tbl_wr_data  = tbl_rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          kind_nxt = req_kind;
          size_nxt = req_size;
          addr_nxt = req_addr;
          move_nxt = 1'b0;
          res_nxt  = '0;
          copy_nxt = '0;
          st_nxt   = ST_OK;
          case (req_kind)
            KIND_ALLOC: begin
              if (req_size == '0) begin
                st_nxt    = ST_ZERO;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FIT;
              end
            end
            KIND_FREE: begin
              state_nxt = (req_addr == '0) ? S_DONE : S_FIND;
            end
            KIND_REALLOC: begin
              if (req_addr != '0) begin
                state_nxt = S_FIND;
              end else if (req_size == '0) begin
                st_nxt    = ST_ZERO;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FIT;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_FIND: begin
        rd_idx_nxt = rd_idx_r + CNT_W'(issue);
        pend_nxt   = issue;
        if (hit) begin
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          if (tbl_rd_data.free) begin
            st_nxt    = ST_BADFREE;
            state_nxt = S_DONE;
          end else if (kind_r == KIND_FREE) begin
            // Mark the block free.
            tbl_wr_en        = 1'b1;
            tbl_wr_data.free = 1'b1;
            state_nxt        = S_DONE;
          end else if (tbl_rd_data.size >= size_r) begin
            res_nxt   = addr_r;
            state_nxt = S_DONE;
          end else begin
            // Too small: remember the old block and look for a new one.
            move_nxt     = 1'b1;
            old_idx_nxt  = pend_idx_r;
            old_size_nxt = tbl_rd_data.size;
            state_nxt    = S_FIT;
          end
        end else if (miss) begin
          st_nxt    = ST_BADFREE;
          state_nxt = S_DONE;
        end
      end

      S_FIT: begin
        rd_idx_nxt = rd_idx_r + CNT_W'(issue);
        pend_nxt   = issue;
        if (hit) begin
          rd_idx_nxt       = '0;
          pend_nxt         = 1'b0;
          tbl_wr_en        = 1'b1;
          tbl_wr_data.free = 1'b0;
          res_nxt          = tbl_rd_data.start;
          state_nxt        = move_r ? S_RELEASE : S_DONE;
        end else if (miss) begin
          state_nxt = S_APPEND;
        end
      end

      S_APPEND: begin
        if (no_room) begin
          res_nxt   = '0;
          st_nxt    = ST_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          tbl_wr_en         = 1'b1;
          tbl_wr_addr       = count_r[IDX_W-1:0];
          tbl_wr_data.free  = 1'b0;
          tbl_wr_data.size  = size_r;
          tbl_wr_data.start = new_start;
          count_nxt         = count_r + CNT_W'(1);
          top_nxt           = need[TOP_W-1:0];
          res_nxt           = new_start;
          state_nxt         = move_r ? S_RELEASE : S_DONE;
        end
      end

      S_RELEASE: begin
        // The move succeeded: free the old block and report its size.
        tbl_wr_en         = 1'b1;
        tbl_wr_addr       = old_idx_r;
        tbl_wr_data.free  = 1'b1;
        tbl_wr_data.size  = old_size_r;
        tbl_wr_data.start = addr_r;
        copy_nxt          = old_size_r;
        state_nxt         = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      count_r     <= '0;
      top_r       <= '0;
      limit_r     <= HEAP_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      pend_r   <= pend_nxt;
      count_r  <= count_nxt;
      top_r    <= top_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (rsp_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    move_r     <= move_nxt;
    old_idx_r  <= old_idx_nxt;
    old_size_r <= old_size_nxt;
    res_r      <= res_nxt;
    copy_r     <= copy_nxt;
    st_r       <= st_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (out_load) begin
      out_addr_r <= res_r;
      out_copy_r <= copy_r;
      out_st_r   <= st_r;
    end
  end

  assign rsp_valid  = out_valid_r;
  assign rsp_addr   = out_addr_r;
  assign rsp_copy   = out_copy_r;
  assign rsp_status = out_st_r;

endmodule : ffa_ctrl
`default_nettype wire

// ===== design/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap block allocator
// Allocate, free and reallocate requests against a table of heap blocks.
// ----------------------------------------------------------------------------
// Each request is one transaction in and one result transaction out. The
// block table has a single read port with registered data and is walked one
// entry per cycle through a shared compare unit. A free, or a reallocate that
// keeps its block, scans the table for its address; an allocate scans for a
// free block that fits and appends a new one when none does; a reallocate
// that moves its block does both and on success frees the old one. An
// allocate or a null reallocate of size zero, a free of null and the unused
// kind go straight to the result register. The block takes no new request
// until the current one has reached the result register, and the next
// request can be accepted in the cycle after that at the earliest; that
// register lets a finished result wait while the next request is worked on.
// A result that still occupies the register holds the next one back until
// out_tready takes it. The heap limit may only be written while no request
// is in progress.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned HEAP_BYTES   = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] request_size, [31:16] payload_address
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] result_address, [31:16] copy_length
  output logic [1:0]       out_tuser,  // [1:0] status
  // Configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [16:0] cfg_wr_data // [16:0] heap_limit
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  entry_t           tbl_wr_data;
  logic             tbl_rd_en;
  logic [IDX_W-1:0] tbl_rd_addr;
  entry_t           tbl_rd_data;

  // Block table.
  ffa_table #(
    .DEPTH (MAX_BLOCKS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  // Sequencer with the shared compare unit.
  ffa_ctrl #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .HEAP_BYTES   (HEAP_BYTES),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_kind    (in_tuser),
    .req_size    (in_tdata[15:0]),
    .req_addr    (in_tdata[31:16]),
    .rsp_valid   (out_tvalid),
    .rsp_ready   (out_tready),
    .rsp_addr    (out_tdata[15:0]),
    .rsp_copy    (out_tdata[31:16]),
    .rsp_status  (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_data (tbl_wr_data),
    .tbl_rd_en   (tbl_rd_en),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_rd_data (tbl_rd_data)
  );

endmodule : first_fit_block_allocator
`default_nettype wire

// ===== design/ffa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_checker: port-level checks of the allocator
// Watches the request and result channels and flags results that break the
// allocator's rules.
// ----------------------------------------------------------------------------
module ffa_checker
  import ffa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // A stalled result transaction holds its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The block is busy in the cycle after it takes a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one still in progress");

  // Every failing result carries a null address and no copy length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == 32'd0))
    else $error("failing result carries an address or copy length");

  // A copy length only comes with a successful move to a real address.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:16] != 16'd0)
      |-> (out_tuser == ST_OK) && (out_tdata[15:0] != 16'd0))
    else $error("copy length without a successful move");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule : ffa_checker

bind first_fit_block_allocator ffa_checker u_ffa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
